>>> design/grm_pkg.sv
// Shared constants, types and helpers of the greedy row-max assignment core.
package grm_pkg;

	localparam int MAX_SIZE   = 4096;
	localparam int SCORE_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_SIZE);
	localparam int SIZE_W     = 13;
	localparam int OUT_IDX_W  = 12;
	localparam int OUT_SCR_W  = 16;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

	// One element on its way from the fetch stage to the select stage.
	typedef struct packed {
		logic                  valid;
		logic [SCORE_BITS-1:0] score;
		logic [IDX_W-1:0]      col;
		logic [IDX_W-1:0]      row;
		logic                  row_end;
		logic                  last;
		logic                  used;
	} grm_item_t;

	// Column to mark as taken once a row is decided.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] col;
	} grm_mark_t;

	// Clamp the programmed size to 1..MAX_SIZE.
	function automatic logic [IDX_W:0] size_in_use(input logic [SIZE_W-1:0] size);
		logic [IDX_W:0] n;
		if (size == '0) begin
			n = (IDX_W + 1)'(1);
		end else if (32'(size) > MAX_SIZE) begin
			n = (IDX_W + 1)'(MAX_SIZE);
		end else begin
			n = (IDX_W + 1)'(size);
		end
		return n;
	endfunction

endpackage

>>> design/grm_score_if.sv
// Input channel: one score element per item.
interface grm_score_if;
	logic                           valid;
	logic                           ready;
	logic [grm_pkg::OUT_SCR_W-1:0]  score;

	modport source (output valid, output score, input ready);
	modport sink   (input valid, input score, output ready);
endinterface

>>> design/grm_result_if.sv
// Output channel: one result item per finished row.
interface grm_result_if;
	logic                           valid;
	logic                           ready;
	logic [grm_pkg::OUT_IDX_W-1:0]  row_index;
	logic [grm_pkg::OUT_IDX_W-1:0]  chosen_column;
	logic [grm_pkg::OUT_SCR_W-1:0]  best_score;
	logic [grm_pkg::OUT_SCR_W-1:0]  worst_score;
	logic [grm_pkg::OUT_IDX_W-1:0]  worst_row;
	logic [grm_pkg::OUT_IDX_W-1:0]  worst_column;
	logic                           last_row;

	modport source (output valid, output row_index, output chosen_column, output best_score,
		output worst_score, output worst_row, output worst_column, output last_row,
		input ready);
	modport sink   (input valid, input row_index, input chosen_column, input best_score,
		input worst_score, input worst_row, input worst_column, input last_row,
		output ready);
endinterface

>>> design/grm_cfg_if.sv
// Configuration write channel for the matrix size register.
interface grm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [grm_pkg::SIZE_W-1:0]   matrix_size;

	modport source (output valid, output matrix_size, input ready);
	modport sink   (input valid, input matrix_size, output ready);
endinterface

>>> design/grm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> design/grm_fetch.sv
// Fetch stage: size register, row/column counters, used-mask RAM and stage 1 register.
module grm_fetch (
	input  logic               clk,
	input  logic               arst_n,
	grm_score_if.sink          scores,
	grm_cfg_if.sink            cfg,
	input  logic               take,
	input  grm_pkg::grm_mark_t mark,
	output grm_pkg::grm_item_t item
);
	import grm_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  col_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W:0]    seen_q;
	logic [IDX_W:0]    n;
	logic              accept;
	logic              row_end;
	logic              last;
	logic              fresh;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic              ram_rdata;

	logic                  valid_s1;
	logic [SCORE_BITS-1:0] score_s1;
	logic [IDX_W-1:0]      col_s1;
	logic [IDX_W-1:0]      row_s1;
	logic                  row_end_s1;
	logic                  last_s1;
	logic                  fresh_s1;
	logic                  fwd_s1;

	assign cfg.ready    = 1'b1;
	assign scores.ready = !valid_s1 || take;
	assign accept       = scores.valid && scores.ready;

	assign n       = size_in_use(size_q);
	assign row_end = ({1'b0, col_q} + (IDX_W + 1)'(1)) >= n;
	assign last    = row_end && (({1'b0, row_q} + (IDX_W + 1)'(1)) >= n);
	// columns at or past the high-water mark were never touched in this matrix
	assign fresh   = {1'b0, col_q} >= seen_q;

	// mark and clear never collide: a clear on column zero only follows reset or a last row
	assign ram_we    = mark.we || (accept && fresh);
	assign ram_waddr = mark.we ? mark.col : col_q;

	grm_ram #(
		.WIDTH (1),
		.DEPTH (MAX_SIZE)
	) u_mask (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (mark.we),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_RESET;
			col_q    <= '0;
			row_q    <= '0;
			seen_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg.valid) begin
				size_q <= cfg.matrix_size;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				col_q    <= row_end ? '0 : col_q + IDX_W'(1);
				if (row_end) begin
					row_q <= last ? '0 : row_q + IDX_W'(1);
				end
				if (last) begin
					seen_q <= '0;
				end else if (fresh) begin
					seen_q <= {1'b0, col_q} + (IDX_W + 1)'(1);
				end
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			score_s1   <= scores.score[SCORE_BITS-1:0];
			col_s1     <= col_q;
			row_s1     <= row_q;
			row_end_s1 <= row_end;
			last_s1    <= last;
			fresh_s1   <= fresh;
			fwd_s1     <= mark.we && (mark.col == col_q);
		end
	end

	always_comb begin
		item.valid   = valid_s1;
		item.score   = score_s1;
		item.col     = col_s1;
		item.row     = row_s1;
		item.row_end = row_end_s1;
		item.last    = last_s1;
		item.used    = !fresh_s1 && (ram_rdata || fwd_s1);
	end
endmodule

>>> design/grm_select.sv
// Select stage: running row maximum, worst-row tracking and result register.
module grm_select (
	input  logic               clk,
	input  logic               arst_n,
	input  grm_pkg::grm_item_t item,
	output logic               take,
	output grm_pkg::grm_mark_t mark,
	grm_result_if.source       results
);
	import grm_pkg::*;

	logic [SCORE_BITS-1:0] best_value_q;
	logic [IDX_W-1:0]      best_index_q;
	logic                  best_found_q;
	logic [SCORE_BITS-1:0] worst_value_q;
	logic [IDX_W-1:0]      worst_row_q;
	logic [IDX_W-1:0]      worst_col_q;
	logic                  out_valid_q;

	logic                  fire;
	logic                  upd;
	logic [SCORE_BITS-1:0] bv_n;
	logic [IDX_W-1:0]      bi_n;
	logic                  bf_n;
	logic [SCORE_BITS-1:0] best;
	logic [IDX_W-1:0]      chosen;
	logic                  wupd;
	logic [SCORE_BITS-1:0] wv_n;
	logic [IDX_W-1:0]      wr_n;
	logic [IDX_W-1:0]      wc_n;

	assign take = !item.row_end || !out_valid_q || results.ready;
	assign fire = item.valid && take;

	always_comb begin
		upd    = !item.used && (!best_found_q || item.score > best_value_q);
		bv_n   = upd ? item.score : best_value_q;
		bi_n   = upd ? item.col : best_index_q;
		bf_n   = upd || best_found_q;
		best   = bf_n ? bv_n : '0;
		chosen = bf_n ? bi_n : '0;
		wupd   = worst_value_q >= best;
		wv_n   = wupd ? best : worst_value_q;
		wr_n   = wupd ? item.row : worst_row_q;
		wc_n   = wupd ? chosen : worst_col_q;
	end

	// the mask is wiped after the last row, so its mark is dropped
	assign mark.we  = fire && item.row_end && !item.last && bf_n;
	assign mark.col = bi_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_value_q  <= '0;
			best_index_q  <= '0;
			best_found_q  <= 1'b0;
			worst_value_q <= '1;
			worst_row_q   <= '0;
			worst_col_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (fire && item.row_end) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (item.row_end) begin
					best_value_q <= '0;
					best_index_q <= '0;
					best_found_q <= 1'b0;
					if (item.last) begin
						worst_value_q <= '1;
						worst_row_q   <= '0;
						worst_col_q   <= '0;
					end else begin
						worst_value_q <= wv_n;
						worst_row_q   <= wr_n;
						worst_col_q   <= wc_n;
					end
				end else begin
					best_value_q <= bv_n;
					best_index_q <= bi_n;
					best_found_q <= bf_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item.row_end) begin
			results.row_index     <= OUT_IDX_W'(item.row);
			results.chosen_column <= OUT_IDX_W'(chosen);
			results.best_score    <= OUT_SCR_W'(best);
			results.worst_score   <= OUT_SCR_W'(wv_n);
			results.worst_row     <= OUT_IDX_W'(wr_n);
			results.worst_column  <= OUT_IDX_W'(wc_n);
			results.last_row      <= item.last;
		end
	end

	assign results.valid = out_valid_q;
endmodule

>>> design/greedy_row_max_assignment_core.sv
// Top level of the greedy row-max assignment core.
// Scores of a square matrix stream in row-major order, one item per cycle unless a
// row's last score waits on a pending result; one result item leaves per finished row.
// The rate is set by the used-mask RAM (one registered read per score) and the loop
// that compares each score against the running row maximum. The mask needs no
// clearing pass after reset or between matrices: a high-water count of the columns
// touched in the current matrix marks every column past it as free, and the first
// visit of a column rewrites its entry. The output register lets new scores keep
// flowing while a result waits to be taken, up to the next row's last score. The
// matrix size register may be written whenever no result is pending.
module greedy_row_max_assignment_core (
	input  logic          clk,
	input  logic          arst_n,
	grm_score_if.sink     scores,
	grm_cfg_if.sink       cfg,
	grm_result_if.source  results
);
	import grm_pkg::*;

	grm_item_t item;
	grm_mark_t mark;
	logic      take;

	// Count rows and columns, read the mask bit, hold the element in stage 1.
	grm_fetch u_fetch (
		.clk    (clk),
		.arst_n (arst_n),
		.scores (scores),
		.cfg    (cfg),
		.take   (take),
		.mark   (mark),
		.item   (item)
	);

	// Advance the row maximum, close rows, mark the chosen column, drive results.
	grm_select u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.take    (take),
		.mark    (mark),
		.results (results)
	);
endmodule
